>>> rtl/hemd_pkg.sv
`timescale 1ns / 1ps
package hemd_pkg;
    localparam int MAX_BINS_DEF      = 1024;
    localparam int SAMPLE_BITS_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 32;
    localparam int IN_BITS     = 32;
    localparam int DIST_BITS   = 33;
    localparam int STATUS_BITS = 2;
    localparam int TOTAL_BITS  = 64;

    localparam logic [STATUS_BITS-1:0] STATUS_VALID    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_ZERO_SUM = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_DIV,
        ST_ACC,
        ST_MEAN,
        ST_OUT
    } state_t;
endpackage

>>> rtl/histogram_earth_movers_distance_top.sv
`timescale 1ns / 1ps
// Loading: one sample pair beat per cycle, the result channel idle.
// After the tlast beat each of the N stored bins is read, started in both lanes, scaled
// serially and accumulated; the mean divider then runs over the total.
// The result is valid once the mean is done, or in the cycle after tlast when a series
// sums to zero; the next series is taken after the result beat.
// Reset (aresetn low, synchronous) clears sums, count and flags; stores are not cleared.
module histogram_earth_movers_distance_top #(
    parameter int MAX_BINS      = hemd_pkg::MAX_BINS_DEF,
    parameter int SAMPLE_BITS   = hemd_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = hemd_pkg::FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] measured_value, [63:32] reference_value
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [32:0] distance, [34:33] status, [39:35] zero
    output logic [39:0] m_tdata
);
    localparam int AW       = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW       = $clog2(MAX_BINS + 1);
    localparam int SUM_BITS = SAMPLE_BITS + CW;
    localparam int SB       = (SAMPLE_BITS < hemd_pkg::IN_BITS) ? SAMPLE_BITS
                                                                : hemd_pkg::IN_BITS;
    localparam int TB       = hemd_pkg::TOTAL_BITS;
    // A normalized bin and any cumulative of them are at most 1.0, one bit above the fraction.
    localparam int QW       = FRACTION_BITS + 1;

    // The two series live in memories; each divider lane scales one series.
    logic [SAMPLE_BITS-1:0] mem_m [MAX_BINS];
    logic [SAMPLE_BITS-1:0] mem_r [MAX_BINS];
    logic [SAMPLE_BITS-1:0] rd_m_reg, rd_r_reg;

    hemd_pkg::state_t state_reg, state_next;
    logic [SUM_BITS-1:0] sum_m_reg, sum_r_reg;
    logic [CW-1:0]       count_reg, idx_reg;
    logic                ovf_reg;
    logic                mean_go_reg;
    logic [QW-1:0]       cum_m_reg, cum_r_reg;
    logic [TB-1:0]       total_reg;
    logic [hemd_pkg::DIST_BITS-1:0]   dist_reg;
    logic [hemd_pkg::STATUS_BITS-1:0] status_reg;

    logic [SAMPLE_BITS-1:0] in_m, in_r;
    logic                   take, room;
    logic                   start_lanes, start_mean;
    logic                   busy_m, busy_r, busy_mean;
    logic [QW-1:0]          q_m, q_r;
    logic [hemd_pkg::DIST_BITS-1:0] q_mean;
    logic [QW-1:0]          ncm, ncr, diff;
    logic [TB:0]            tsum;
    logic [SUM_BITS-1:0]    next_sum_m, next_sum_r;
    logic [CW-1:0]          next_count;

    always_comb begin
        in_m = '0;
        in_r = '0;
        in_m[SB-1:0] = s_tdata[SB-1:0];
        in_r[SB-1:0] = s_tdata[32 +: SB];
    end

    assign s_tready = (state_reg == hemd_pkg::ST_LOAD);
    assign take     = s_tvalid && s_tready;
    assign room     = (count_reg < CW'(MAX_BINS));
    assign next_sum_m = room ? sum_m_reg + SUM_BITS'(in_m) : sum_m_reg;
    assign next_sum_r = room ? sum_r_reg + SUM_BITS'(in_r) : sum_r_reg;
    assign next_count = room ? count_reg + 1'b1 : count_reg;

    always_ff @(posedge aclk) begin
        if (take && room) begin
            mem_m[count_reg[AW-1:0]] <= in_m;
            mem_r[count_reg[AW-1:0]] <= in_r;
        end
        rd_m_reg <= mem_m[idx_reg[AW-1:0]];
        rd_r_reg <= mem_r[idx_reg[AW-1:0]];
    end

    // Each lane returns floor(v * 2^FRACTION_BITS / sum) directly.
    hemd_div #(.NUM_BITS(SAMPLE_BITS), .DEN_BITS(SUM_BITS), .SHIFT(FRACTION_BITS),
               .Q_BITS(QW)) u_div_m (
        .aclk(aclk), .aresetn(aresetn), .start(start_lanes), .num(rd_m_reg),
        .den(sum_m_reg), .busy(busy_m), .quot(q_m)
    );
    hemd_div #(.NUM_BITS(SAMPLE_BITS), .DEN_BITS(SUM_BITS), .SHIFT(FRACTION_BITS),
               .Q_BITS(QW)) u_div_r (
        .aclk(aclk), .aresetn(aresetn), .start(start_lanes), .num(rd_r_reg),
        .den(sum_r_reg), .busy(busy_r), .quot(q_r)
    );
    // Mean: total / count. Every difference is at most 1.0, so the mean fits the
    // distance field.
    hemd_div #(.NUM_BITS(TB), .DEN_BITS(CW), .SHIFT(0),
               .Q_BITS(hemd_pkg::DIST_BITS)) u_div_mean (
        .aclk(aclk), .aresetn(aresetn), .start(start_mean), .num(total_reg),
        .den(count_reg), .busy(busy_mean), .quot(q_mean)
    );

    assign ncm  = cum_m_reg + q_m;
    assign ncr  = cum_r_reg + q_r;
    assign diff = (ncm >= ncr) ? ncm - ncr : ncr - ncm;
    assign tsum = {1'b0, total_reg} + (TB+1)'(diff);

    always_comb begin
        state_next  = state_reg;
        start_lanes = 1'b0;
        start_mean  = 1'b0;
        case (state_reg)
            hemd_pkg::ST_LOAD: begin
                if (take && s_tlast) begin
                    if (next_sum_m == '0 || next_sum_r == '0) begin
                        state_next = hemd_pkg::ST_OUT;
                    end else begin
                        state_next = hemd_pkg::ST_READ;
                    end
                end
            end
            hemd_pkg::ST_READ: state_next = hemd_pkg::ST_DIV;
            hemd_pkg::ST_DIV: begin
                start_lanes = 1'b1;
                state_next  = hemd_pkg::ST_ACC;
            end
            hemd_pkg::ST_ACC: begin
                if (!busy_m && !busy_r) begin
                    if (idx_reg + 1'b1 == count_reg) begin
                        state_next = hemd_pkg::ST_MEAN;
                    end else begin
                        state_next = hemd_pkg::ST_READ;
                    end
                end
            end
            hemd_pkg::ST_MEAN: begin
                // The first cycle here starts the mean, once the last difference is in total.
                start_mean = mean_go_reg;
                if (!busy_mean && !mean_go_reg) state_next = hemd_pkg::ST_OUT;
            end
            hemd_pkg::ST_OUT: if (m_tready) state_next = hemd_pkg::ST_LOAD;
            default: state_next = hemd_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hemd_pkg::ST_LOAD;
            sum_m_reg <= '0;
            sum_r_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            mean_go_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mean_go_reg <= (state_reg == hemd_pkg::ST_ACC) &&
                           (state_next == hemd_pkg::ST_MEAN);
            if (take) begin
                sum_m_reg <= next_sum_m;
                sum_r_reg <= next_sum_r;
                count_reg <= next_count;
                ovf_reg   <= ovf_reg | !room;
            end
            if (state_reg == hemd_pkg::ST_OUT && m_tready) begin
                sum_m_reg <= '0;
                sum_r_reg <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && s_tlast) begin
            idx_reg    <= '0;
            cum_m_reg  <= '0;
            cum_r_reg  <= '0;
            total_reg  <= '0;
            dist_reg   <= '0;
            status_reg <= hemd_pkg::STATUS_ZERO_SUM;
        end
        if (state_reg == hemd_pkg::ST_ACC && !busy_m && !busy_r) begin
            cum_m_reg <= ncm;
            cum_r_reg <= ncr;
            total_reg <= tsum[TB] ? {TB{1'b1}} : tsum[TB-1:0];
            idx_reg   <= idx_reg + 1'b1;
        end
        if (state_reg == hemd_pkg::ST_MEAN && !busy_mean && !mean_go_reg) begin
            dist_reg   <= q_mean;
            status_reg <= ovf_reg ? hemd_pkg::STATUS_OVERFLOW : hemd_pkg::STATUS_VALID;
        end
    end

    assign m_tvalid = (state_reg == hemd_pkg::ST_OUT);
    assign m_tdata  = {5'd0, status_reg, dist_reg};
endmodule

>>> rtl/hemd_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The dividend is
// num * 2^SHIFT, so the fraction bits come out without a wide shift.
// It works through all NUM_BITS + SHIFT dividend bits and keeps the low Q_BITS quotient bits.
module hemd_div #(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 42,
    parameter int SHIFT    = 0,
    parameter int Q_BITS   = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                busy,
    output logic [Q_BITS-1:0]   quot
);
    localparam int W        = NUM_BITS + SHIFT;
    localparam int CNT_BITS = $clog2(W + 1);

    logic [W-1:0]        dvd_reg;
    logic [DEN_BITS:0]   rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [Q_BITS-1:0]   q_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DEN_BITS:0]   trial;

    // Dividend bits are fed MSB first, one per cycle, for all W bits.
    always_comb begin
        trial = {rem_reg[DEN_BITS-1:0], dvd_reg[W-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_BITS'(W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= W'(num) << SHIFT;
            rem_reg <= '0;
            den_reg <= den;
            q_reg   <= '0;
        end else if (cnt_reg != '0) begin
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_reg <= trial - {1'b0, den_reg};
                q_reg   <= {q_reg[Q_BITS-2:0], 1'b1};
            end else begin
                rem_reg <= trial;
                q_reg   <= {q_reg[Q_BITS-2:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
endmodule

>>> dv/histogram_earth_movers_distance_top_tb.sv
`timescale 1ns / 1ps
module histogram_earth_movers_distance_top_tb;
    localparam int BIN_DEPTH  = hemd_pkg::MAX_BINS_DEF;
    localparam int IDLE_LIMIT = 400000;
    localparam int ITEM_GOAL  = 1550;

    typedef struct packed {
        logic [hemd_pkg::STATUS_BITS-1:0] status;
        logic [hemd_pkg::DIST_BITS-1:0]   distance;
    } emd_result_t;

    // Tracks the histogram pair being loaded and the distances still owed.
    class emd_scoreboard;
        logic [31:0] meas_bins[$];
        logic [31:0] ref_bins[$];
        logic [41:0] meas_total;
        logic [41:0] ref_total;
        bit          dropped;
        emd_result_t owed[$];
        string       why;

        function void clear_series();
            meas_bins.delete();
            ref_bins.delete();
            meas_total = '0;
            ref_total  = '0;
            dropped    = 0;
        endfunction

        function logic [63:0] scaled_bin(logic [31:0] v, logic [41:0] total);
            logic [95:0] num;
            num = {v, 32'd0};
            return 64'(num / {54'd0, total});
        endfunction

        function emd_result_t distance_of_series();
            emd_result_t res;
            logic [63:0] cum_meas, cum_ref, area;
            cum_meas = '0;
            cum_ref  = '0;
            area     = '0;
            res      = '0;
            if (meas_total == 0 || ref_total == 0) begin
                res.status = hemd_pkg::STATUS_ZERO_SUM;
                return res;
            end
            foreach (meas_bins[i]) begin
                cum_meas += scaled_bin(meas_bins[i], meas_total);
                cum_ref  += scaled_bin(ref_bins[i], ref_total);
                area += (cum_meas >= cum_ref) ? cum_meas - cum_ref : cum_ref - cum_meas;
            end
            res.distance = hemd_pkg::DIST_BITS'(area / 64'(meas_bins.size()));
            res.status   = dropped ? hemd_pkg::STATUS_OVERFLOW : hemd_pkg::STATUS_VALID;
            return res;
        endfunction

        function void note_beat(logic [31:0] m, logic [31:0] r, logic last);
            if (meas_bins.size() < BIN_DEPTH) begin
                meas_bins.push_back(m);
                ref_bins.push_back(r);
                meas_total += 42'(m);
                ref_total  += 42'(r);
            end else begin
                dropped = 1;
            end
            if (last) begin
                owed.push_back(distance_of_series());
                clear_series();
            end
        endfunction

        // Returns 1 when the beat matches the oldest owed result.
        function bit check_result(logic [39:0] data);
            emd_result_t want;
            emd_result_t got;
            got = data[34:0];
            if (owed.size() == 0) begin
                why = $sformatf("unexpected result %h", data);
                return 0;
            end
            want = owed.pop_front();
            if (data[39:35] != 0) begin
                why = $sformatf("pad bits not zero: %h", data);
                return 0;
            end
            if (got.status != want.status) begin
                why = $sformatf("status %0d, want %0d", got.status, want.status);
                return 0;
            end
            if (got.distance != want.distance) begin
                why = $sformatf("distance %h, want %h", got.distance, want.distance);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [31:0] measured_value, [63:32] reference_value
    logic [63:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    // [32:0] distance, [34:33] status, [39:35] zero
    logic [39:0] m_tdata;

    emd_scoreboard sb;
    int errors;
    int idle_cycles;
    int items_sent;

    histogram_earth_movers_distance_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    task automatic report(string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Most gaps are short; now and then one is long.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0)  return $urandom_range(1, 3);
        return 0;
    endfunction

    // Sample values of varied magnitude so that every bit toggles.
    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'($urandom_range(0, 255));
            2: return 32'hFFFF_FFFF;
            3: return $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // Presents one beat and holds it until the block takes it.
    task automatic send_beat(logic [31:0] m, logic [31:0] r, logic last, int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= {r, m};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_series(int len, bit quiet);
        for (int i = 0; i < len; i++)
            send_beat(rand_sample(), rand_sample(), i == len - 1, quiet ? 0 : gap_len());
    endtask

    // Receiver: bursts of random stalls alternate with stretches of steady accept.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(50, 400)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(5, 40)) begin
                    m_tready <= ($urandom_range(0, 2) != 0);
                    @(posedge aclk);
                    if (!m_tready && $urandom_range(0, 15) == 0) begin
                        repeat ($urandom_range(20, 80)) @(posedge aclk);
                    end
                end
            end
        end
    end

    // Monitor both channels at each edge, before this edge's updates land.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (s_tvalid && s_tready) begin
                sb.note_beat(s_tdata[31:0], s_tdata[63:32], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (!sb.check_result(m_tdata)) report(sb.why);
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[histogram_earth_movers_distance_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        sb.clear_series();
        errors      = 0;
        idle_cycles = 0;
        items_sent  = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: a single-bin pair, identical series, extremes, zero sums.
        send_beat(32'd1, 32'd1, 1'b1, 0);
        send_beat(32'hFFFF_FFFF, 32'd0, 1'b0, 0);
        send_beat(32'd0, 32'hFFFF_FFFF, 1'b1, 2);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
        send_beat(32'd0, 32'd5, 1'b0, 0);           // measured series all zero
        send_beat(32'd0, 32'd7, 1'b1, 0);
        send_beat(32'd9, 32'd0, 1'b1, 0);           // reference series all zero
        send_beat(32'd0, 32'd0, 1'b1, 0);           // both zero
        send_beat(32'd1, 32'd0, 1'b0, 0);
        send_beat(32'd0, 32'd0, 1'b0, 0);
        send_beat(32'd0, 32'd1, 1'b1, 0);           // mass at opposite ends
        send_beat(32'h8000_0000, 32'h0000_0001, 1'b0, 1);
        send_beat(32'h0000_0001, 32'h8000_0000, 1'b0, 0);
        send_beat(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 0);
        send_beat(32'd3, 32'd1, 1'b0, 0);
        send_beat(32'd1, 32'd3, 1'b0, 0);
        send_beat(32'd2, 32'd2, 1'b1, 0);

        // Random series, mostly short; one fills the store and runs past it.
        while (items_sent < ITEM_GOAL) begin
            if (items_sent > 200 && items_sent < 260) begin
                // Hold off until the block has answered everything.
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (sb.owed.size() != 0);
                send_series(BIN_DEPTH + 3, 1);
            end else if ($urandom_range(0, 9) == 0) begin
                send_series($urandom_range(20, 60), $urandom_range(0, 1));
            end else begin
                send_series($urandom_range(1, 6), $urandom_range(0, 3) == 0);
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        do @(posedge aclk); while (sb.owed.size() != 0);
        repeat (200) @(posedge aclk);
        if (sb.owed.size() != 0) report("results left outstanding");

        if (errors == 0) begin
            $display("[histogram_earth_movers_distance_top] OK");
        end else begin
            $display("[histogram_earth_movers_distance_top] ERROR");
        end
        $finish;
    end
endmodule
